// File: hdl/acfd_pkg.sv
// Shared constants, codes and types of the autocorrelation flip-delta evaluator.
package acfd_pkg;

	// sizes
	localparam int MAX_LEN    = 256;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int LEN_W      = IDX_W + 1;
	localparam int POS_W      = 8;
	localparam int SEQLEN_W   = 9;
	localparam int TARGET_W   = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CORR_W     = 10;
	localparam int DELTA_W    = 4;
	localparam int COST_W     = 26;
	localparam int ALLOW_W    = 26;
	localparam int SUM_W      = 12;
	localparam int MAG_W      = 11;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 56;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
	localparam logic signed [CORR_W:0] CORR_HI = (CORR_W+1)'((1 << (CORR_W - 1)) - 1);
	localparam logic signed [CORR_W:0] CORR_LO = (CORR_W+1)'(-(1 << (CORR_W - 1)));

	// correlation change of a flip is FLIP_SCALE * s[p] * (a + b), a + b = 0 or +-2
	localparam int FLIP_SCALE = -2;
	localparam logic [DELTA_W-1:0] DELTA_NEG = DELTA_W'(2 * FLIP_SCALE);
	localparam logic [DELTA_W-1:0] DELTA_POS = DELTA_W'(-2 * FLIP_SCALE);

	// register indexes
	localparam logic [0:0] CFG_TARGET = 1'b0;
	localparam logic [0:0] CFG_LENGTH = 1'b1;

	// status codes
	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_RANGE = 1'b1;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_REBUILD = 2'd1,
		REQ_FLIP    = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLIP_SP,
		ST_FLIP_SPW,
		ST_FLIP_RUN,
		ST_FLIP_DRAIN,
		ST_FLIP_DECIDE,
		ST_COMMIT_RUN,
		ST_COMMIT_DRAIN,
		ST_RB_CORR,
		ST_RB_STORE,
		ST_RB_CLEAR,
		ST_RB_COST_RUN,
		ST_RB_COST_DRAIN,
		ST_FINISH
	} state_t;

	// sequence element write
	typedef struct packed {
		logic             en;
		logic             sel;
		logic [IDX_W-1:0] addr;
		logic             val;
	} seq_wr_t;

	// correlation pair write
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [CORR_W-1:0] first;
		logic [CORR_W-1:0] second;
	} corr_wr_t;

	// flip delta write
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [DELTA_W-1:0] data;
	} delta_wr_t;

	// one cost term request
	typedef struct packed {
		logic               valid;
		logic [CORR_W-1:0]  ca;
		logic [CORR_W-1:0]  cb;
		logic [DELTA_W-1:0] d;
	} cost_in_t;

	// cost unit status
	typedef struct packed {
		logic              busy;
		logic [COST_W-1:0] acc;
	} cost_st_t;

endpackage

// File: hdl/acfd_seq_store.sv
// Storage of both element sequences, one write and two registered reads a cycle.
module acfd_seq_store
	import acfd_pkg::*;
(
	input  logic             clk,
	input  seq_wr_t          wr,
	input  logic [IDX_W-1:0] rd0_addr,
	input  logic [IDX_W-1:0] rd1_addr,
	output logic [1:0]       rd0,      // [0] first sequence, [1] second sequence
	output logic [1:0]       rd1       // [0] first sequence, [1] second sequence
);

	logic first_mem  [MAX_LEN];
	logic second_mem [MAX_LEN];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en && !wr.sel) begin
			first_mem[wr.addr] <= wr.val;
		end
		if (wr.en && wr.sel) begin
			second_mem[wr.addr] <= wr.val;
		end
	end

	// two read ports, registered
	always_ff @(posedge clk) begin
		rd0 <= {second_mem[rd0_addr], first_mem[rd0_addr]};
		rd1 <= {second_mem[rd1_addr], first_mem[rd1_addr]};
	end

endmodule

// File: hdl/acfd_corr_store.sv
// Correlation pair memory with per-shift valid bits, and the flip delta memory.
module acfd_corr_store
	import acfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  corr_wr_t           wr,
	input  delta_wr_t          dwr,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [CORR_W-1:0]  rd_first,
	output logic [CORR_W-1:0]  rd_second,
	output logic [DELTA_W-1:0] rd_delta
);

	logic [2*CORR_W-1:0] corr_mem  [MAX_LEN];
	logic [DELTA_W-1:0]  delta_mem [MAX_LEN];
	logic [MAX_LEN-1:0]  vld_q;
	logic                rd_vld_q;
	logic [2*CORR_W-1:0] rd_corr_q;

	// memories
	always_ff @(posedge clk) begin
		if (wr.en) begin
			corr_mem[wr.addr] <= {wr.second, wr.first};
		end
		if (dwr.en) begin
			delta_mem[dwr.addr] <= dwr.data;
		end
		rd_corr_q <= corr_mem[rd_addr];
		rd_delta  <= delta_mem[rd_addr];
	end

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_first  = rd_vld_q ? rd_corr_q[CORR_W-1:0]        : '0;
	assign rd_second = rd_vld_q ? rd_corr_q[2*CORR_W-1:CORR_W] : '0;

endmodule

// File: hdl/acfd_cost_unit.sv
// Shared cost pipeline: (|Ca+Cb+d| - target)^2 per shift, saturating sum.
module acfd_cost_unit
	import acfd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  cost_in_t            cin,
	input  logic [TARGET_W-1:0] target,
	output cost_st_t            cst
);

	logic                    v1_q, v2_q, v3_q;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [SUM_W-1:0] gap_s2;
	logic [SQ_W-1:0]         sq_s3;
	logic [COST_W-1:0]       acc_q;
	logic signed [SUM_W-1:0] mag;
	logic signed [SUM_W-1:0] agap;
	logic [COST_W:0]         acc_sum;

	// valid flags and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			v3_q  <= 1'b0;
			acc_q <= '0;
		end else begin
			v1_q <= cin.valid;
			v2_q <= v1_q;
			v3_q <= v2_q;
			if (clr) begin
				acc_q <= '0;
			end else if (v3_q) begin
				acc_q <= (acc_sum > (COST_W+1)'(COST_MAX)) ? COST_MAX : acc_sum[COST_W-1:0];
			end
		end
	end

	// stage arithmetic
	always_comb begin
		mag     = (sum_s1 < 0) ? -sum_s1 : sum_s1;
		agap    = (gap_s2 < 0) ? -gap_s2 : gap_s2;
		acc_sum = (COST_W+1)'(acc_q) + (COST_W+1)'(sq_s3);
	end

	always_ff @(posedge clk) begin
		sum_s1 <= SUM_W'($signed(cin.ca)) + SUM_W'($signed(cin.cb)) + SUM_W'($signed(cin.d));
		gap_s2 <= mag - $signed(SUM_W'(target));
		sq_s3  <= agap[MAG_W-1:0] * agap[MAG_W-1:0];
	end

	assign cst.busy = v1_q | v2_q | v3_q;
	assign cst.acc  = acc_q;

endmodule

// File: hdl/acf_flip_delta_evaluator_core.sv
// Top level: request sequencer, configuration, stores, cost unit and result register.
//
//  port group        | dir | payload (lowest bits first)
//  s_tvalid/s_tready | in  | s_tdata: position[7:0], element_value[8], accept_allowance[34:9]
//                    |     | s_tuser: req_type[1:0], seq_select[2]
//  m_tvalid/m_tready | out | m_tdata: accepted[0], candidate_cost[26:1], held_cost[52:27]
//                    |     | m_tuser: status
//  cfg_we/cfg_index  | in  | cfg_data: 0 target_level, 1 seq_length
//
// One request at a time; the block takes no new request before the last one's reply is loaded.
// The rate is set by the two-port sequence memory and the shared cost pipeline, one shift
// per cycle in the flip, commit and cost walks. Reset is asynchronous and takes effect at
// once; correlations read as zero through per-shift valid bits. A held result blocks only
// the next reply, not acceptance.
module acf_flip_delta_evaluator_core
	import acfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position, element_value, accept_allowance
	input  logic [IN_USER_W-1:0]  s_tuser,   // req_type, seq_select
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // accepted, candidate_cost, held_cost
	output logic                  m_tuser,   // status
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [IDX_W-1:0] u_q, u_d, i_q, i_d, j_q, j_d, fwd_q, fwd_d, bwd_q, bwd_d;
	logic [IDX_W-1:0] u_s1, u_s1_d;
	logic             eval_s1, eval_s1_d, rbacc_s1, rbacc_s1_d;
	logic             rbcost_s1, rbcost_s1_d, commit_s1, commit_s1_d;
	logic signed [CORR_W-1:0] suma_q, suma_d, sumb_q, sumb_d, suma_nx, sumb_nx;

	logic               sp_q, sp_d, sel_q, sel_d;
	logic [IDX_W-1:0]   pos_q, pos_d;
	logic [ALLOW_W-1:0] allow_q, allow_d;
	logic               res_acc_q, res_acc_d, res_stat_q, res_stat_d;
	logic [COST_W-1:0]  res_cand_q, res_cand_d;
	logic [COST_W-1:0]  held_q, held_d;

	logic [TARGET_W-1:0] target_q;
	logic [SEQLEN_W-1:0] len_q;
	logic [LEN_W-1:0]    n_eff, nm1;

	logic               m_tvalid_q, m_tvalid_d, out_load;
	logic               out_acc_q, out_stat_q;
	logic [COST_W-1:0]  out_cand_q, out_cur_q;

	logic               cost_clr;
	cost_in_t           cin;
	cost_st_t           cst;
	seq_wr_t            seq_wr;
	corr_wr_t           corr_wr_fsm, corr_wr;
	delta_wr_t          delta_wr;
	logic [IDX_W-1:0]   rd0_addr, rd1_addr, crd_addr;
	logic [1:0]         rd0, rd1;
	logic [CORR_W-1:0]  rd_first, rd_second;
	logic [DELTA_W-1:0] rd_delta;

	// input word fields
	req_t               in_req;
	logic               in_sel, in_elem, in_range;
	logic [POS_W-1:0]   in_pos;
	logic [ALLOW_W-1:0] in_allow;

	assign in_req   = req_t'(s_tuser[1:0]);
	assign in_sel   = s_tuser[2];
	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_elem  = s_tdata[POS_W];
	assign in_allow = s_tdata[POS_W+ALLOW_W:POS_W+1];

	// effective length, clamped to 2..MAX_LEN
	always_comb begin
		if (len_q < SEQLEN_W'(2)) begin
			n_eff = LEN_W'(2);
		end else if (LEN_W'(len_q) > LEN_W'(MAX_LEN) || len_q > SEQLEN_W'(MAX_LEN)) begin
			n_eff = LEN_W'(MAX_LEN);
		end else begin
			n_eff = LEN_W'(len_q);
		end
		nm1      = n_eff - LEN_W'(1);
		in_range = LEN_W'(in_pos) < n_eff;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			len_q    <= SEQLEN_W'(MAX_LEN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET: target_q <= cfg_data[TARGET_W-1:0];
				CFG_LENGTH: len_q    <= cfg_data[SEQLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// first-stage datapath: flip delta, rebuild products, commit update
	logic                     a_bit, b_bit;
	logic [DELTA_W-1:0]       d_s1;
	logic signed [CORR_W:0]   commit_sum;
	logic [CORR_W-1:0]        commit_val;
	logic [CORR_W-1:0]        commit_cur;

	always_comb begin
		a_bit = sel_q ? rd0[1] : rd0[0];
		b_bit = sel_q ? rd1[1] : rd1[0];
		if (a_bit != b_bit) begin
			d_s1 = '0;
		end else begin
			d_s1 = (sp_q == a_bit) ? DELTA_NEG : DELTA_POS;
		end

		suma_nx = suma_q;
		sumb_nx = sumb_q;
		if (rbacc_s1) begin
			suma_nx = (rd0[0] ^ rd1[0]) ? suma_q - CORR_W'(1) : suma_q + CORR_W'(1);
			sumb_nx = (rd0[1] ^ rd1[1]) ? sumb_q - CORR_W'(1) : sumb_q + CORR_W'(1);
		end

		commit_cur = sel_q ? rd_second : rd_first;
		commit_sum = (CORR_W+1)'($signed(commit_cur)) + (CORR_W+1)'($signed(rd_delta));
		if (commit_sum > CORR_HI) begin
			commit_val = CORR_HI[CORR_W-1:0];
		end else if (commit_sum < CORR_LO) begin
			commit_val = CORR_LO[CORR_W-1:0];
		end else begin
			commit_val = commit_sum[CORR_W-1:0];
		end

		cin.valid = eval_s1 | rbcost_s1;
		cin.ca    = rd_first;
		cin.cb    = rd_second;
		cin.d     = eval_s1 ? d_s1 : '0;

		delta_wr.en   = eval_s1;
		delta_wr.addr = u_s1;
		delta_wr.data = d_s1;

		corr_wr = corr_wr_fsm;
		if (commit_s1) begin
			corr_wr.en     = 1'b1;
			corr_wr.addr   = u_s1;
			corr_wr.first  = sel_q ? rd_first  : commit_val;
			corr_wr.second = sel_q ? commit_val : rd_second;
		end
	end

	// sequencer: next state and strobes
	logic [LEN_W-1:0] u_inc;
	logic             flip_ok;

	always_comb begin
		state_d     = state_q;
		u_d         = u_q;
		i_d         = i_q;
		j_d         = j_q;
		fwd_d       = fwd_q;
		bwd_d       = bwd_q;
		u_s1_d      = u_q;
		eval_s1_d   = 1'b0;
		rbacc_s1_d  = 1'b0;
		rbcost_s1_d = 1'b0;
		commit_s1_d = 1'b0;
		suma_d      = suma_nx;
		sumb_d      = sumb_nx;
		sp_d        = sp_q;
		sel_d       = sel_q;
		pos_d       = pos_q;
		allow_d     = allow_q;
		res_acc_d   = res_acc_q;
		res_stat_d  = res_stat_q;
		res_cand_d  = res_cand_q;
		held_d      = held_q;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		cost_clr    = 1'b0;
		rd0_addr    = i_q;
		rd1_addr    = j_q;
		crd_addr    = u_q;
		seq_wr      = '0;
		corr_wr_fsm = '0;
		u_inc       = LEN_W'(u_q) + LEN_W'(1);
		flip_ok     = (COST_W+1)'(cst.acc) <= (COST_W+1)'(held_q) + (COST_W+1)'(allow_q);

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					sel_d      = in_sel;
					pos_d      = IDX_W'(in_pos);
					allow_d    = in_allow;
					res_acc_d  = 1'b0;
					res_cand_d = '0;
					res_stat_d = STAT_OK;
					state_d    = ST_FINISH;
					case (in_req)
						REQ_WRITE: begin
							if (in_range) begin
								seq_wr.en   = 1'b1;
								seq_wr.sel  = in_sel;
								seq_wr.addr = IDX_W'(in_pos);
								seq_wr.val  = in_elem;
							end else begin
								res_stat_d = STAT_RANGE;
							end
						end
						REQ_REBUILD: begin
							u_d     = '0;
							i_d     = '0;
							j_d     = '0;
							suma_d  = '0;
							sumb_d  = '0;
							state_d = ST_RB_CORR;
						end
						REQ_FLIP: begin
							if (in_range) begin
								state_d = ST_FLIP_SP;
							end else begin
								res_stat_d = STAT_RANGE;
							end
						end
						default: ;
					endcase
				end
			end

			// read the element to be flipped, set up both walk pointers
			ST_FLIP_SP: begin
				rd0_addr = pos_q;
				u_d      = IDX_W'(1);
				fwd_d    = (LEN_W'(pos_q) + LEN_W'(1) == n_eff) ? '0 : pos_q + IDX_W'(1);
				bwd_d    = (pos_q == '0) ? IDX_W'(nm1) : pos_q - IDX_W'(1);
				state_d  = ST_FLIP_SPW;
			end

			ST_FLIP_SPW: begin
				sp_d     = sel_q ? rd0[1] : rd0[0];
				cost_clr = 1'b1;
				state_d  = ST_FLIP_RUN;
			end

			// one shift per cycle: s[p+u], s[p-u] and the correlation pair
			ST_FLIP_RUN: begin
				rd0_addr  = fwd_q;
				rd1_addr  = bwd_q;
				crd_addr  = u_q;
				eval_s1_d = 1'b1;
				fwd_d     = (LEN_W'(fwd_q) + LEN_W'(1) == n_eff) ? '0 : fwd_q + IDX_W'(1);
				bwd_d     = (bwd_q == '0) ? IDX_W'(nm1) : bwd_q - IDX_W'(1);
				u_d       = u_q + IDX_W'(1);
				if (LEN_W'(u_q) == nm1) begin
					state_d = ST_FLIP_DRAIN;
				end
			end

			ST_FLIP_DRAIN: begin
				if (!eval_s1 && !cst.busy) begin
					state_d = ST_FLIP_DECIDE;
				end
			end

			ST_FLIP_DECIDE: begin
				res_cand_d = cst.acc;
				state_d    = ST_FINISH;
				if (flip_ok) begin
					res_acc_d   = 1'b1;
					held_d      = cst.acc;
					seq_wr.en   = 1'b1;
					seq_wr.sel  = sel_q;
					seq_wr.addr = pos_q;
					seq_wr.val  = ~sp_q;
					u_d         = IDX_W'(1);
					state_d     = ST_COMMIT_RUN;
				end
			end

			// add the stored deltas into the flipped sequence's correlations
			ST_COMMIT_RUN: begin
				crd_addr    = u_q;
				commit_s1_d = 1'b1;
				u_d         = u_q + IDX_W'(1);
				if (LEN_W'(u_q) == nm1) begin
					state_d = ST_COMMIT_DRAIN;
				end
			end

			ST_COMMIT_DRAIN: begin
				if (!commit_s1) begin
					state_d = ST_FINISH;
				end
			end

			// rebuild: inner walk i over the sequence, j = (i + u) mod L
			ST_RB_CORR: begin
				rd0_addr   = i_q;
				rd1_addr   = j_q;
				rbacc_s1_d = 1'b1;
				i_d        = i_q + IDX_W'(1);
				j_d        = (LEN_W'(j_q) + LEN_W'(1) == n_eff) ? '0 : j_q + IDX_W'(1);
				if (LEN_W'(i_q) == nm1) begin
					state_d = ST_RB_STORE;
				end
			end

			ST_RB_STORE: begin
				corr_wr_fsm.en     = 1'b1;
				corr_wr_fsm.addr   = u_q;
				corr_wr_fsm.first  = suma_nx;
				corr_wr_fsm.second = sumb_nx;
				suma_d             = '0;
				sumb_d             = '0;
				if (u_inc < n_eff) begin
					u_d     = u_inc[IDX_W-1:0];
					i_d     = '0;
					j_d     = u_inc[IDX_W-1:0];
					state_d = ST_RB_CORR;
				end else if (u_q == IDX_W'(MAX_LEN - 1)) begin
					u_d      = IDX_W'(1);
					cost_clr = 1'b1;
					state_d  = ST_RB_COST_RUN;
				end else begin
					u_d     = u_inc[IDX_W-1:0];
					state_d = ST_RB_CLEAR;
				end
			end

			// shifts at or beyond the length are cleared
			ST_RB_CLEAR: begin
				corr_wr_fsm.en   = 1'b1;
				corr_wr_fsm.addr = u_q;
				u_d              = u_inc[IDX_W-1:0];
				if (u_q == IDX_W'(MAX_LEN - 1)) begin
					u_d      = IDX_W'(1);
					cost_clr = 1'b1;
					state_d  = ST_RB_COST_RUN;
				end
			end

			ST_RB_COST_RUN: begin
				crd_addr    = u_q;
				rbcost_s1_d = 1'b1;
				u_d         = u_q + IDX_W'(1);
				if (LEN_W'(u_q) == nm1) begin
					state_d = ST_RB_COST_DRAIN;
				end
			end

			ST_RB_COST_DRAIN: begin
				if (!rbcost_s1 && !cst.busy) begin
					held_d     = cst.acc;
					res_cand_d = cst.acc;
					state_d    = ST_FINISH;
				end
			end

			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase

		m_tvalid_d = out_load | (m_tvalid_q & ~m_tready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			u_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			fwd_q      <= '0;
			bwd_q      <= '0;
			eval_s1    <= 1'b0;
			rbacc_s1   <= 1'b0;
			rbcost_s1  <= 1'b0;
			commit_s1  <= 1'b0;
			suma_q     <= '0;
			sumb_q     <= '0;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			u_q        <= u_d;
			i_q        <= i_d;
			j_q        <= j_d;
			fwd_q      <= fwd_d;
			bwd_q      <= bwd_d;
			eval_s1    <= eval_s1_d;
			rbacc_s1   <= rbacc_s1_d;
			rbcost_s1  <= rbcost_s1_d;
			commit_s1  <= commit_s1_d;
			suma_q     <= suma_d;
			sumb_q     <= sumb_d;
			held_q     <= held_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		u_s1       <= u_s1_d;
		sp_q       <= sp_d;
		sel_q      <= sel_d;
		pos_q      <= pos_d;
		allow_q    <= allow_d;
		res_acc_q  <= res_acc_d;
		res_stat_q <= res_stat_d;
		res_cand_q <= res_cand_d;
		if (out_load) begin
			out_acc_q  <= res_acc_q;
			out_stat_q <= res_stat_q;
			out_cand_q <= res_cand_q;
			out_cur_q  <= held_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {(OUT_DATA_W - 2*COST_W - 1)'(0), out_cur_q, out_cand_q, out_acc_q};

	acfd_seq_store u_seq_store (
		.clk      (clk),
		.wr       (seq_wr),
		.rd0_addr (rd0_addr),
		.rd1_addr (rd1_addr),
		.rd0      (rd0),
		.rd1      (rd1)
	);

	acfd_corr_store u_corr_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (corr_wr),
		.dwr       (delta_wr),
		.rd_addr   (crd_addr),
		.rd_first  (rd_first),
		.rd_second (rd_second),
		.rd_delta  (rd_delta)
	);

	acfd_cost_unit u_cost_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cost_clr),
		.cin    (cin),
		.target (target_q),
		.cst    (cst)
	);

endmodule

// File: dv/flip_cost_checker.sv
`timescale 1ns / 100ps
// Reply checker for the flip-delta evaluator: tracks requests, predicts and compares replies.
module flip_cost_checker
	import acfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position, element_value, accept_allowance
	input  logic [IN_USER_W-1:0]  s_tuser,   // req_type, seq_select
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // accepted, candidate_cost, held_cost
	input  logic                  m_tuser,   // status
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic              accepted;
		logic [COST_W-1:0] candidate;
		logic [COST_W-1:0] current;
		logic              status;
	} reply_t;

	// shadow of the block's state; sequence bit 1 means -1
	bit                  seq_bit   [2][MAX_LEN];
	int                  corr      [2][MAX_LEN];
	int                  flip_step [MAX_LEN];
	logic [COST_W-1:0]   cost_held;
	logic [TARGET_W-1:0] target;
	logic [SEQLEN_W-1:0] span_reg;
	reply_t              due_replies [$];
	reply_t              want;

	function automatic int level_of(input bit b);
		return b ? -1 : 1;
	endfunction

	function automatic int clip_corr(input int x);
		if (x < CORR_LO) return CORR_LO;
		if (x > CORR_HI) return CORR_HI;
		return x;
	endfunction

	function automatic logic [COST_W-1:0] clip_cost(input longint c);
		return (c > longint'(COST_MAX)) ? COST_MAX : COST_W'(c);
	endfunction

	// squared gap between |summed correlation| and the target level
	function automatic longint shift_cost(input int v);
		longint gap;
		gap = longint'(v < 0 ? -v : v) - longint'(target);
		return gap * gap;
	endfunction

	// applies one request to the shadow state and returns the reply it should give
	function automatic reply_t evaluate_request(input logic [1:0] kind, input logic sel,
			input logic [POS_W-1:0] pos, input logic val, input logic [ALLOW_W-1:0] allow);
		reply_t r;
		int     n, p, sp, d, acc;
		longint sum;
		r = '0;
		n = int'(span_reg);
		if (n < 2) n = 2;
		if (n > MAX_LEN) n = MAX_LEN;
		p = int'(pos);
		case (kind)
		REQ_WRITE: begin
			if (p < n) seq_bit[sel][p] = val;
			else r.status = STAT_RANGE;
		end
		REQ_REBUILD: begin
			for (int s = 0; s < 2; s++)
				for (int u = 0; u < MAX_LEN; u++) begin
					acc = 0;
					if (u < n)
						for (int i = 0; i < n; i++)
							acc += level_of(seq_bit[s][i]) * level_of(seq_bit[s][(i + u) % n]);
					corr[s][u] = clip_corr(acc);
				end
			sum = 0;
			for (int u = 1; u < n; u++)
				sum += shift_cost(corr[0][u] + corr[1][u]);
			cost_held = clip_cost(sum);
			r.candidate = cost_held;
		end
		REQ_FLIP: begin
			if (p >= n) begin
				r.status = STAT_RANGE;
			end else begin
				sp = level_of(seq_bit[sel][p]);
				sum = 0;
				for (int u = 1; u < n; u++) begin
					d = FLIP_SCALE * sp * (level_of(seq_bit[sel][(p + u) % n])
						+ level_of(seq_bit[sel][(p + n - u) % n]));
					flip_step[u] = d;
					sum += shift_cost(corr[sel][u] + corr[!sel][u] + d);
				end
				r.candidate = clip_cost(sum);
				// commit when within the allowance above the held cost
				if (longint'(r.candidate) <= longint'(cost_held) + longint'(allow)) begin
					r.accepted = 1'b1;
					seq_bit[sel][p] = !seq_bit[sel][p];
					for (int u = 1; u < n; u++)
						corr[sel][u] = clip_corr(corr[sel][u] + flip_step[u]);
					cost_held = r.candidate;
				end
			end
		end
		default: ;
		endcase
		r.current = cost_held;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_v);
		$display("%0t reply check: %s got %0d, predicted %0d", $time, what, got, exp_v);
		errors++;
	endtask

	// sample at the rising edge: configuration, then replies, then new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++)
				for (int u = 0; u < MAX_LEN; u++) begin
					seq_bit[s][u] = 1'b0;
					corr[s][u] = 0;
				end
			for (int u = 0; u < MAX_LEN; u++)
				flip_step[u] = 0;
			cost_held = '0;
			target = '0;
			span_reg = SEQLEN_W'(MAX_LEN);
			due_replies.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TARGET) target = cfg_data[TARGET_W-1:0];
				else span_reg = cfg_data[SEQLEN_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (due_replies.size() == 0) begin
					report_mismatch("reply word with none due, held_cost",
						m_tdata[2*COST_W:COST_W+1], 0);
				end else begin
					want = due_replies.pop_front();
					if (m_tdata[0] !== want.accepted)
						report_mismatch("accepted", m_tdata[0], want.accepted);
					if (m_tdata[COST_W:1] !== want.candidate)
						report_mismatch("candidate_cost", m_tdata[COST_W:1], want.candidate);
					if (m_tdata[2*COST_W:COST_W+1] !== want.current)
						report_mismatch("held_cost", m_tdata[2*COST_W:COST_W+1],
							want.current);
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
				end
			end
			if (s_tvalid && s_tready)
				due_replies.insert(due_replies.size(), evaluate_request(s_tuser[1:0],
					s_tuser[2], s_tdata[POS_W-1:0], s_tdata[POS_W],
					s_tdata[POS_W+ALLOW_W:POS_W+1]));
		end
		pending = due_replies.size();
	end

endmodule

// File: dv/acf_flip_delta_evaluator_core_test.sv
`timescale 1ns / 100ps
// Testbench top for the flip-delta evaluator: clock, reset, request and stall stimulus, verdict.
module acf_flip_delta_evaluator_core_test;
	import acfd_pkg::*;

	localparam logic [1:0]         REQ_SPARE = 2'd3;   // request type with no function
	localparam logic [ALLOW_W-1:0] ALLOW_ALL = {ALLOW_W{1'b1}};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // position, element_value, accept_allowance
	logic [IN_USER_W-1:0]  s_tuser  = '0;   // req_type, seq_select
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // accepted, candidate_cost, held_cost
	logic                  m_tuser;         // status
	logic                  cfg_we    = 1'b0;
	logic [0:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int errors;
	int pending;
	bit written [2][MAX_LEN];   // elements written so far, never read before that
	bit calm_send, calm_recv;   // stretches without idling
	int span;                   // effective length of the current phase

	always #5 clk = ~clk;

	acf_flip_delta_evaluator_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	flip_cost_checker reply_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	// one request word: random gap, then hold until accepted
	task automatic send_request(input logic [1:0] kind, input logic sel,
			input logic [POS_W-1:0] pos, input logic val, input logic [ALLOW_W-1:0] allow);
		int gap;
		if ($urandom_range(0, 39) == 0) calm_send = !calm_send;
		gap = calm_send ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {{(IN_DATA_W-POS_W-1-ALLOW_W){1'b0}}, allow, val, pos};
		s_tuser  <= {sel, kind};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every reply
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly in-range flips and writes; rebuilds only at short lengths
	task automatic random_request();
		int                 pick, p;
		logic               sel;
		logic [ALLOW_W-1:0] allow;
		pick  = $urandom_range(0, 99);
		sel   = 1'($urandom);
		allow = ALLOW_W'($urandom);
		case ($urandom_range(0, 4))
		0: allow = '0;
		1: allow = ALLOW_W'($urandom_range(0, 64));
		2: allow = ALLOW_W'($urandom_range(0, 4096));
		3: allow = ALLOW_ALL;
		default: ;
		endcase
		if (pick < 8 && span <= 32) begin
			send_request(REQ_REBUILD, sel, POS_W'($urandom), 1'($urandom), allow);
		end else if (pick < 28) begin
			p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_LEN - 1)
				: $urandom_range(0, span - 1);
			if (p < span) written[sel][p] = 1'b1;
			send_request(REQ_WRITE, sel, POS_W'(p), 1'($urandom), allow);
		end else if (pick < 31) begin
			send_request(REQ_SPARE, sel, POS_W'($urandom), 1'($urandom), allow);
		end else begin
			p = $urandom_range(0, span - 1);
			if ($urandom_range(0, 11) == 0) p = $urandom_range(0, MAX_LEN - 1);
			send_request(REQ_FLIP, sel, POS_W'(p), 1'($urandom), allow);
		end
	endtask

	// new settings, complete both sequences below the length, rebuild, then random words
	task automatic run_phase(input logic [CFG_DATA_W-1:0] tgt,
			input logic [CFG_DATA_W-1:0] len_val, input int count);
		settle();
		write_reg(CFG_TARGET, tgt);
		write_reg(CFG_LENGTH, len_val);
		span = int'(len_val[SEQLEN_W-1:0]);
		if (span < 2) span = 2;
		if (span > MAX_LEN) span = MAX_LEN;
		for (int s = 0; s < 2; s++)
			for (int p = 0; p < span; p++)
				if (!written[s][p]) begin
					written[s][p] = 1'b1;
					send_request(REQ_WRITE, s[0], POS_W'(p), 1'($urandom), ALLOW_W'($urandom));
				end
		send_request(REQ_REBUILD, 1'($urandom), POS_W'($urandom), 1'($urandom), ALLOW_W'($urandom));
		repeat (count) random_request();
	endtask

	// receiver: random stall before each reply word
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0) calm_recv = !calm_recv;
			hold = calm_recv ? 0 : $urandom_range(0, 17);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// stimulus and verdict
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: short sequences, range edges, every request type
		write_reg(CFG_TARGET, 3);
		write_reg(CFG_LENGTH, 4);
		span = 4;
		for (int s = 0; s < 2; s++)
			for (int p = 0; p < 4; p++) begin
				written[s][p] = 1'b1;
				send_request(REQ_WRITE, s[0], POS_W'(p), 1'((p + s) & 1), '0);
			end
		send_request(REQ_WRITE, 1'b0, 8'hFF, 1'b1, ALLOW_ALL);     // far beyond length
		send_request(REQ_WRITE, 1'b1, 8'd4, 1'b0, '0);             // first position past end
		send_request(REQ_REBUILD, 1'b1, 8'hFF, 1'b1, ALLOW_ALL);   // position ignored
		send_request(REQ_FLIP, 1'b0, 8'd0, 1'b0, '0);
		send_request(REQ_FLIP, 1'b1, 8'd3, 1'b1, ALLOW_ALL);
		send_request(REQ_FLIP, 1'b0, 8'd4, 1'b0, ALLOW_ALL);
		send_request(REQ_FLIP, 1'b1, 8'hFF, 1'b0, '0);
		send_request(REQ_SPARE, 1'b1, 8'hFF, 1'b1, ALLOW_ALL);
		send_request(REQ_SPARE, 1'b0, 8'd0, 1'b0, '0);
		send_request(REQ_FLIP, 1'b0, 8'd2, 1'b0, 1);
		send_request(REQ_REBUILD, 1'b0, 8'd0, 1'b0, '0);

		// random phases; below-range, above-range and masked lengths included
		run_phase(5, 16, 120);
		run_phase(0, 0, 60);
		run_phase(12, 32, 150);
		run_phase(10'h3FF, 80, 80);      // costs can saturate
		run_phase(512, 2, 40);
		run_phase(8, 24, 150);
		run_phase(20, 10'h1FF, 40);      // full length
		run_phase(3, 9, 150);
		run_phase(10'h3FF, 10'h203, 60);

		settle();
		repeat (32) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("acf_flip_delta_evaluator_core: match");
		else
			$display("acf_flip_delta_evaluator_core: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("acf_flip_delta_evaluator_core: mismatch");
		$finish;
	end

endmodule
